[src/rpeg_pkg.sv]
`timescale 1ns / 1ps

package rpeg_pkg;

    // Fixed-point formats of the data path.
    localparam int FRAC_BITS  = 16;   // Q16.16 coordinates, projections and errors
    localparam int COEF_FRAC  = 12;   // Q20.12 matrix coefficients
    localparam int WORD_W     = 32;
    localparam int MUL_W      = 33;   // signed multiplier operand width
    localparam int PROD_W     = 2 * MUL_W;
    localparam int H_W        = 56;   // homogeneous accumulator width
    localparam int DIV_W      = 56;   // divider divisor and remainder width
    localparam int SSUM_W     = 65;   // sum of two squares
    localparam int ROOT_W     = 64;
    localparam int COUNT_W    = 21;   // kept_count port width
    localparam int CFG_DATA_W = 64;
    localparam int CFG_IDX_W  = 3;
    localparam int NUM_COEF   = 12;
    localparam int CNT_W      = 6;    // sequencer step counter
    localparam int DIV_STEPS  = 32;
    localparam int ROOT_STEPS = 32;
    localparam int MAC_STEPS  = 9;

    localparam int MAX_POINTS_DEFAULT = 1048576;

    localparam logic [WORD_W-1:0] ERR_MAX      = 32'hFFFF_FFFF;
    localparam logic [WORD_W-1:0] POS_SAT      = 32'h7FFF_FFFF;
    localparam logic [WORD_W-1:0] NEG_SAT      = 32'h8000_0000;
    localparam logic [WORD_W-1:0] MAX_ERR_INIT = 32'hFFFF_FFFF;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_ROW0_LO  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROW0_HI  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ROW1_LO  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ROW1_HI  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ROW2_LO  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ROW2_HI  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_ERR  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_FILTER   = 3'd7;

    typedef struct packed {
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic signed [31:0] point_z;
        logic signed [31:0] obs_u;
        logic signed [31:0] obs_v;
        logic               last;
    } in_t;

    typedef struct packed {
        logic               keep;
        logic               depth_bad;
        logic [31:0]        error;
        logic signed [31:0] proj_u;
        logic signed [31:0] proj_v;
        logic               set_done;
        logic [31:0]        mean_error;
        logic [20:0]        kept_count;
    } out_t;

    typedef struct packed {
        logic [NUM_COEF-1:0][WORD_W-1:0] coef;
        logic [WORD_W-1:0]               max_error;
        logic                            filter_enable;
    } cfg_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL,
        ST_DEPTH,
        ST_DIV_LOAD,
        ST_DIV_RUN,
        ST_DIV_STORE,
        ST_SQUARE,
        ST_SQRT,
        ST_ACCUM,
        ST_EMIT
    } state_t;

    typedef enum logic [1:0] {
        DIV_U,
        DIV_V,
        DIV_MEAN
    } div_op_t;

    typedef enum logic [1:0] {
        MUL_MAC,
        MUL_SQU,
        MUL_SQV
    } mul_sel_t;

    typedef struct packed {
        logic     load;
        logic     mul_en;
        mul_sel_t mul_sel;
        logic [3:0] mac_idx;   // {row, column} of the coefficient
        logic     acc_en;
        logic     ssum_load;
        logic     ssum_add;
        logic     div_load;
        logic     div_step;
        logic     div_store;
        div_op_t  div_op;
        logic     root_load;
        logic     root_step;
        logic     accum;
        logic     emit;
    } cmd_t;

    typedef struct packed {
        logic h2_zero;
        logic last;
        logic kept_nz;
    } stat_t;

endpackage

[src/rpeg_ctrl.sv]
`timescale 1ns / 1ps

module rpeg_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            point_valid,
    output logic            point_ready,
    input  logic            result_ready,
    output logic            result_valid,
    input  rpeg_pkg::stat_t stat,
    output rpeg_pkg::cmd_t  cmd
);

    rpeg_pkg::state_t  state_reg, state_next;
    rpeg_pkg::div_op_t op_reg, op_next;
    logic [rpeg_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    logic valid_reg, valid_next;

    // Maps a multiply step to the {row, column} of its coefficient.
    function automatic logic [3:0] mac_map(input logic [rpeg_pkg::CNT_W-1:0] c);
        logic [3:0] r;
        case (c)
            6'd0:    r = 4'b00_00;
            6'd1:    r = 4'b00_01;
            6'd2:    r = 4'b00_10;
            6'd3:    r = 4'b01_00;
            6'd4:    r = 4'b01_01;
            6'd5:    r = 4'b01_10;
            6'd6:    r = 4'b10_00;
            6'd7:    r = 4'b10_01;
            6'd8:    r = 4'b10_10;
            default: r = 4'b00_00;
        endcase
        return r;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rpeg_pkg::ST_IDLE;
            op_reg    <= rpeg_pkg::DIV_U;
            cnt_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            op_reg    <= op_next;
            cnt_reg   <= cnt_next;
            valid_reg <= valid_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        op_next     = op_reg;
        cnt_next    = cnt_reg;
        valid_next  = valid_reg;
        cmd         = '0;
        cmd.mul_sel = rpeg_pkg::MUL_MAC;
        cmd.div_op  = op_reg;
        point_ready = 1'b0;

        if (valid_reg && result_ready)
        begin
            valid_next = 1'b0;
        end

        case (state_reg)
            rpeg_pkg::ST_IDLE:
            begin
                point_ready = 1'b1;
                if (point_valid)
                begin
                    cmd.load   = 1'b1;
                    cnt_next   = '0;
                    state_next = rpeg_pkg::ST_MUL;
                end
            end
            rpeg_pkg::ST_MUL:
            begin
                cmd.mul_en  = (cnt_reg < rpeg_pkg::CNT_W'(rpeg_pkg::MAC_STEPS));
                cmd.mac_idx = mac_map(cnt_reg);
                cmd.acc_en  = (cnt_reg != '0);
                if (cnt_reg == rpeg_pkg::CNT_W'(rpeg_pkg::MAC_STEPS))
                begin
                    state_next = rpeg_pkg::ST_DEPTH;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            rpeg_pkg::ST_DEPTH:
            begin
                op_next = rpeg_pkg::DIV_U;
                if (stat.h2_zero)
                begin
                    state_next = rpeg_pkg::ST_ACCUM;
                end
                else
                begin
                    state_next = rpeg_pkg::ST_DIV_LOAD;
                end
            end
            rpeg_pkg::ST_DIV_LOAD:
            begin
                if (op_reg == rpeg_pkg::DIV_MEAN && !stat.kept_nz)
                begin
                    state_next = rpeg_pkg::ST_EMIT;
                end
                else
                begin
                    cmd.div_load = 1'b1;
                    cnt_next     = '0;
                    state_next   = rpeg_pkg::ST_DIV_RUN;
                end
            end
            rpeg_pkg::ST_DIV_RUN:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == rpeg_pkg::CNT_W'(rpeg_pkg::DIV_STEPS - 1))
                begin
                    state_next = rpeg_pkg::ST_DIV_STORE;
                end
            end
            rpeg_pkg::ST_DIV_STORE:
            begin
                cmd.div_store = 1'b1;
                cnt_next      = '0;
                case (op_reg)
                    rpeg_pkg::DIV_U:
                    begin
                        op_next    = rpeg_pkg::DIV_V;
                        state_next = rpeg_pkg::ST_DIV_LOAD;
                    end
                    rpeg_pkg::DIV_V:
                    begin
                        state_next = rpeg_pkg::ST_SQUARE;
                    end
                    default:
                    begin
                        state_next = rpeg_pkg::ST_EMIT;
                    end
                endcase
            end
            rpeg_pkg::ST_SQUARE:
            begin
                cnt_next = cnt_reg + 1'b1;
                case (cnt_reg)
                    6'd0:
                    begin
                        cmd.mul_en  = 1'b1;
                        cmd.mul_sel = rpeg_pkg::MUL_SQU;
                    end
                    6'd1:
                    begin
                        cmd.mul_en    = 1'b1;
                        cmd.mul_sel   = rpeg_pkg::MUL_SQV;
                        cmd.ssum_load = 1'b1;
                    end
                    6'd2:
                    begin
                        cmd.ssum_add = 1'b1;
                    end
                    default:
                    begin
                        cmd.root_load = 1'b1;
                        cnt_next      = '0;
                        state_next    = rpeg_pkg::ST_SQRT;
                    end
                endcase
            end
            rpeg_pkg::ST_SQRT:
            begin
                cmd.root_step = 1'b1;
                cnt_next      = cnt_reg + 1'b1;
                if (cnt_reg == rpeg_pkg::CNT_W'(rpeg_pkg::ROOT_STEPS - 1))
                begin
                    state_next = rpeg_pkg::ST_ACCUM;
                end
            end
            rpeg_pkg::ST_ACCUM:
            begin
                cmd.accum = 1'b1;
                op_next   = rpeg_pkg::DIV_MEAN;
                if (stat.last)
                begin
                    state_next = rpeg_pkg::ST_DIV_LOAD;
                end
                else
                begin
                    state_next = rpeg_pkg::ST_EMIT;
                end
            end
            rpeg_pkg::ST_EMIT:
            begin
                if (!valid_reg || result_ready)
                begin
                    cmd.emit   = 1'b1;
                    valid_next = 1'b1;
                    state_next = rpeg_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = rpeg_pkg::ST_IDLE;
            end
        endcase
    end

    assign result_valid = valid_reg;

endmodule

[src/rpeg_dp.sv]
`timescale 1ns / 1ps

module rpeg_dp #(
    parameter int MAX_POINTS = rpeg_pkg::MAX_POINTS_DEFAULT
) (
    input  logic            clk,
    input  logic            rst_n,
    input  rpeg_pkg::cfg_t  cfg,
    input  rpeg_pkg::in_t   point_data,
    input  rpeg_pkg::cmd_t  cmd,
    output rpeg_pkg::stat_t stat,
    output rpeg_pkg::out_t  result_data
);

    localparam int KW     = $clog2(MAX_POINTS + 1);
    localparam int SUM_W  = KW + rpeg_pkg::WORD_W;
    localparam int OVF_SH = 31 - rpeg_pkg::FRAC_BITS;
    localparam int LOW_PAD = rpeg_pkg::WORD_W - rpeg_pkg::FRAC_BITS;
    localparam int BIAS_SH = rpeg_pkg::FRAC_BITS - rpeg_pkg::COEF_FRAC;
    localparam int H_W    = rpeg_pkg::H_W;
    localparam int DIV_W  = rpeg_pkg::DIV_W;

    rpeg_pkg::in_t  in_reg;
    rpeg_pkg::out_t out_reg;

    logic signed [H_W-1:0]               h_reg [3];
    logic signed [rpeg_pkg::PROD_W-1:0]  prod_reg;
    logic [1:0]                          prow_reg;
    logic [rpeg_pkg::SSUM_W-1:0]         ssum_reg;

    logic [DIV_W-1:0]  rem_reg, dvs_reg;
    logic [31:0]       shf_reg, quo_reg;
    logic              ovf_reg, neg_reg;

    logic [rpeg_pkg::ROOT_W-1:0] s_reg, res_reg, bit_reg;

    logic signed [31:0] pu_reg, pv_reg;
    logic [31:0]        mean_reg, err_reg;
    logic               keep_reg;

    logic [KW-1:0]    kcnt_reg;
    logic [SUM_W-1:0] esum_reg;

    // Multiplier operand selection.
    logic signed [rpeg_pkg::MUL_W-1:0] mul_a, mul_b, du, dv;
    logic [31:0] coef_sel;
    logic signed [31:0] coord_sel;
    logic signed [rpeg_pkg::PROD_W-1:0] prod_shift;

    assign du = $signed({pu_reg[31], pu_reg}) - $signed({in_reg.obs_u[31], in_reg.obs_u});
    assign dv = $signed({pv_reg[31], pv_reg}) - $signed({in_reg.obs_v[31], in_reg.obs_v});
    assign coef_sel = cfg.coef[cmd.mac_idx];

    always_comb
    begin
        case (cmd.mac_idx[1:0])
            2'd0:    coord_sel = in_reg.point_x;
            2'd1:    coord_sel = in_reg.point_y;
            default: coord_sel = in_reg.point_z;
        endcase
        case (cmd.mul_sel)
            rpeg_pkg::MUL_SQU:
            begin
                mul_a = du;
                mul_b = du;
            end
            rpeg_pkg::MUL_SQV:
            begin
                mul_a = dv;
                mul_b = dv;
            end
            default:
            begin
                mul_a = $signed({coef_sel[31], coef_sel});
                mul_b = $signed({coord_sel[31], coord_sel});
            end
        endcase
    end

    assign prod_shift = prod_reg >>> rpeg_pkg::COEF_FRAC;

    // Divider operands: magnitudes of the homogeneous terms.
    logic signed [H_W-1:0] num_s;
    logic [DIV_W-1:0] num_abs, den_abs;
    logic [DIV_W:0]   trial;
    logic [DIV_W:0]   trial_sub;
    logic [31:0]      quo_signed, div_result;

    assign num_s   = (cmd.div_op == rpeg_pkg::DIV_V) ? h_reg[1] : h_reg[0];
    assign num_abs = num_s[H_W-1] ? DIV_W'(-num_s) : DIV_W'(num_s);
    assign den_abs = h_reg[2][H_W-1] ? DIV_W'(-h_reg[2]) : DIV_W'(h_reg[2]);
    assign trial     = {rem_reg, shf_reg[31]};
    assign trial_sub = trial - {1'b0, dvs_reg};
    assign quo_signed = neg_reg ? (~quo_reg + 1'b1) : quo_reg;
    assign div_result = ovf_reg ? (neg_reg ? rpeg_pkg::NEG_SAT : rpeg_pkg::POS_SAT)
                                : quo_signed;

    // Square root step.
    logic [rpeg_pkg::ROOT_W-1:0] root_try;
    assign root_try = res_reg + bit_reg;

    // Error and gate decision.
    logic        bad;
    logic [31:0] err_val;
    logic        keep_val;
    assign bad      = (h_reg[2] == '0);
    assign err_val  = (bad || ssum_reg[rpeg_pkg::SSUM_W-1]) ? rpeg_pkg::ERR_MAX
                                                             : res_reg[31:0];
    assign keep_val = !bad && (!cfg.filter_enable || (err_val < cfg.max_error));

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            in_reg   <= point_data;
            pu_reg   <= '0;
            pv_reg   <= '0;
            mean_reg <= '0;
            for (int r = 0; r < 3; r++)
            begin
                h_reg[r] <= $signed({{(H_W-32){cfg.coef[r*4+3][31]}}, cfg.coef[r*4+3]})
                            <<< BIAS_SH;
            end
        end
        if (cmd.mul_en)
        begin
            prod_reg <= mul_a * mul_b;
            prow_reg <= cmd.mac_idx[3:2];
        end
        if (cmd.acc_en)
        begin
            h_reg[prow_reg] <= h_reg[prow_reg] + $signed(prod_shift[H_W-1:0]);
        end
        if (cmd.ssum_load)
        begin
            ssum_reg <= {1'b0, prod_reg[63:0]};
        end
        if (cmd.ssum_add)
        begin
            ssum_reg <= ssum_reg + {1'b0, prod_reg[63:0]};
        end
        if (cmd.div_load)
        begin
            quo_reg <= '0;
            if (cmd.div_op == rpeg_pkg::DIV_MEAN)
            begin
                rem_reg <= {{(DIV_W-KW){1'b0}}, esum_reg[SUM_W-1:32]};
                shf_reg <= esum_reg[31:0];
                dvs_reg <= {{(DIV_W-KW){1'b0}}, kcnt_reg};
                ovf_reg <= 1'b0;
                neg_reg <= 1'b0;
            end
            else
            begin
                rem_reg <= num_abs >> rpeg_pkg::FRAC_BITS;
                shf_reg <= {num_abs[rpeg_pkg::FRAC_BITS-1:0], {LOW_PAD{1'b0}}};
                dvs_reg <= den_abs;
                ovf_reg <= ({{OVF_SH{1'b0}}, num_abs} >= {den_abs, {OVF_SH{1'b0}}});
                neg_reg <= num_s[H_W-1] ^ h_reg[2][H_W-1];
            end
        end
        if (cmd.div_step)
        begin
            shf_reg <= {shf_reg[30:0], 1'b0};
            if (!trial_sub[DIV_W])
            begin
                rem_reg <= trial_sub[DIV_W-1:0];
                quo_reg <= {quo_reg[30:0], 1'b1};
            end
            else
            begin
                rem_reg <= trial[DIV_W-1:0];
                quo_reg <= {quo_reg[30:0], 1'b0};
            end
        end
        if (cmd.div_store)
        begin
            case (cmd.div_op)
                rpeg_pkg::DIV_U: pu_reg   <= div_result;
                rpeg_pkg::DIV_V: pv_reg   <= div_result;
                default:         mean_reg <= quo_reg;
            endcase
        end
        if (cmd.root_load)
        begin
            s_reg   <= ssum_reg[63:0];
            res_reg <= '0;
            bit_reg <= {2'b01, {(rpeg_pkg::ROOT_W-2){1'b0}}};
        end
        if (cmd.root_step)
        begin
            bit_reg <= bit_reg >> 2;
            if (s_reg >= root_try)
            begin
                s_reg   <= s_reg - root_try;
                res_reg <= (res_reg >> 1) + bit_reg;
            end
            else
            begin
                res_reg <= res_reg >> 1;
            end
        end
        if (cmd.accum)
        begin
            err_reg  <= err_val;
            keep_reg <= keep_val;
        end
        if (cmd.emit)
        begin
            out_reg.keep       <= keep_reg;
            out_reg.depth_bad  <= bad;
            out_reg.error      <= err_reg;
            out_reg.proj_u     <= pu_reg;
            out_reg.proj_v     <= pv_reg;
            out_reg.set_done   <= in_reg.last;
            out_reg.mean_error <= in_reg.last ? mean_reg : '0;
            out_reg.kept_count <= in_reg.last ? rpeg_pkg::COUNT_W'(kcnt_reg) : '0;
        end
    end

    // Set accumulators.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kcnt_reg <= '0;
            esum_reg <= '0;
        end
        else if (cmd.emit && in_reg.last)
        begin
            kcnt_reg <= '0;
            esum_reg <= '0;
        end
        else if (cmd.accum && keep_val && (kcnt_reg < KW'(MAX_POINTS)))
        begin
            kcnt_reg <= kcnt_reg + 1'b1;
            esum_reg <= esum_reg + SUM_W'(err_val);
        end
    end

    assign stat.h2_zero = bad;
    assign stat.last    = in_reg.last;
    assign stat.kept_nz = (kcnt_reg != '0);
    assign result_data  = out_reg;

endmodule

[src/reprojection_error_gate_top.sv]
`timescale 1ns / 1ps

// Reprojection error gate.
// Each point transaction carries a 3D point and its observed image point.
// The block projects the point through the configured 3x4 matrix, divides
// by depth, measures the distance to the observation and decides whether
// the point is kept. A transaction marked last also returns the kept count
// and the mean error of the set, and then clears the set accumulators.
// Both channels are valid/ready; every point yields exactly one result.
// A point with good depth passes through the nine products of the shared
// multiplier, two depth divisions, the squaring of both differences, a
// 32-step square root and the error gate before its result is written.
// A last point with kept points adds a mean division. A zero depth point
// skips the divisions, the squaring and the root. The next point is
// accepted the cycle after its result is written, so a new point is never
// taken while one is in work. If the receiver stalls, the result holds its
// payload and the next point waits before its result, which stalls input.
// Reset clears the accumulators, drops result_valid, loads a zero matrix,
// an all-ones threshold and filtering on. Write setup only when idle.
module reprojection_error_gate_top #(
    parameter int MAX_POINTS = rpeg_pkg::MAX_POINTS_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                point_valid,
    output logic                                point_ready,
    input  rpeg_pkg::in_t                       point_data,
    output logic                                result_valid,
    input  logic                                result_ready,
    output rpeg_pkg::out_t                      result_data,
    input  logic                                cfg_we,
    input  logic [rpeg_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [rpeg_pkg::CFG_DATA_W-1:0]     cfg_data
);

    rpeg_pkg::cfg_t  cfg_reg;
    rpeg_pkg::cmd_t  cmd;
    rpeg_pkg::stat_t stat;

    // Configuration registers. Each matrix register holds two coefficients,
    // the lower-numbered one in the low word.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.coef          <= '0;
            cfg_reg.max_error     <= rpeg_pkg::MAX_ERR_INIT;
            cfg_reg.filter_enable <= 1'b1;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                rpeg_pkg::REG_MAX_ERR:
                begin
                    cfg_reg.max_error <= cfg_data[31:0];
                end
                rpeg_pkg::REG_FILTER:
                begin
                    cfg_reg.filter_enable <= cfg_data[0];
                end
                default:
                begin
                    cfg_reg.coef[{cfg_index, 1'b0}] <= cfg_data[31:0];
                    cfg_reg.coef[{cfg_index, 1'b1}] <= cfg_data[63:32];
                end
            endcase
        end
    end

    rpeg_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .point_valid  (point_valid),
        .point_ready  (point_ready),
        .result_ready (result_ready),
        .result_valid (result_valid),
        .stat         (stat),
        .cmd          (cmd)
    );

    rpeg_dp #(
        .MAX_POINTS (MAX_POINTS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .point_data  (point_data),
        .cmd         (cmd),
        .stat        (stat),
        .result_data (result_data)
    );

endmodule

[src/rpeg_checker.sv]
`timescale 1ns / 1ps

module rpeg_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           point_valid,
    input logic           point_ready,
    input logic           result_valid,
    input logic           result_ready,
    input rpeg_pkg::out_t result_data
);

    // A stalled result stays offered.
    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid)
        else $error("result dropped while stalled");

    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> $stable(result_data))
        else $error("result payload changed while stalled");

    // Only one point is in work at a time.
    a_one_point: assert property (@(posedge clk) disable iff (!rst_n)
        point_valid && point_ready |=> !point_ready)
        else $error("second point accepted while busy");

    a_set_fields: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_data.set_done |->
            result_data.mean_error == '0 && result_data.kept_count == '0)
        else $error("set summary shown on a point that is not last");

    a_bad_depth: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_data.depth_bad |->
            !result_data.keep && result_data.error == rpeg_pkg::ERR_MAX &&
            result_data.proj_u == '0 && result_data.proj_v == '0)
        else $error("zero depth result is inconsistent");

endmodule

bind reprojection_error_gate_top rpeg_checker u_rpeg_checker (.*);
